/* hdl/rtks_pkg.sv */
// ----------------------------------------------------------------------------
// rtks_pkg
// Shared widths, request codes and controller/datapath signal groups for the
// record table key search block.
// ----------------------------------------------------------------------------
package rtks_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;

    // fixed field widths
    localparam int REQ_W = 2;
    localparam int IDX_W = 8;
    localparam int KEY_W = 32;
    localparam int CNT_W = 9;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_LINEAR = 2'd1,
        REQ_BINARY = 2'd2
    } t_req_type;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic wr_en;
        logic set_wr_res;
        logic start_lin;
        logic lin_step;
        logic start_bin;
        logic bin_issue;
        logic bin_update;
        logic set_hit;
        logic set_miss;
        logic push_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic lin_hit;
        logic lin_miss;
        logic bin_live;
        logic bin_hit;
        logic out_free;
    } t_status;

endpackage

/* hdl/rtks_req_if.sv */
// ----------------------------------------------------------------------------
// rtks_req_if
// Request channel: valid/ready handshake with one request item as payload.
// ----------------------------------------------------------------------------
interface rtks_req_if import rtks_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] roll_number;
    logic signed [KEY_W-1:0] batch_value;

    modport source (
        output valid, req_type, entry_index, roll_number, batch_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_index, roll_number, batch_value,
        output ready
    );

endinterface

/* hdl/rtks_rsp_if.sv */
// ----------------------------------------------------------------------------
// rtks_rsp_if
// Result channel: valid/ready handshake with one result item as payload.
// ----------------------------------------------------------------------------
interface rtks_rsp_if import rtks_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [IDX_W-1:0]        match_index;
    logic signed [KEY_W-1:0] matched_roll_number;
    logic signed [KEY_W-1:0] matched_batch;

    modport source (
        output valid, found, match_index, matched_roll_number, matched_batch,
        input  ready
    );

    modport sink (
        input  valid, found, match_index, matched_roll_number, matched_batch,
        output ready
    );

endinterface

/* hdl/rtks_ram.sv */
// ----------------------------------------------------------------------------
// rtks_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rtks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rtks_dpath.sv */
// ----------------------------------------------------------------------------
// rtks_dpath
// Datapath: count register, record RAM, scan and halving bounds, result
// holding register and output register.
// ----------------------------------------------------------------------------
module rtks_dpath import rtks_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [KEY_W-1:0] i_roll_number,
    input  logic signed [KEY_W-1:0] i_batch_value,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_ready,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [IDX_W-1:0]        o_match_index,
    output logic signed [KEY_W-1:0] o_matched_roll_number,
    output logic signed [KEY_W-1:0] o_matched_batch
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0]        r_entry_count;
    logic [CW-1:0]           active_cnt;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic [AW-1:0]           r_rd_addr;
    logic                    r_rd_valid;

    logic                    r_res_found;
    logic [IDX_W-1:0]        r_res_idx;
    logic signed [KEY_W-1:0] r_res_key;
    logic signed [KEY_W-1:0] r_res_batch;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [IDX_W-1:0]        r_out_idx;
    logic signed [KEY_W-1:0] r_out_key;
    logic signed [KEY_W-1:0] r_out_batch;

    logic                    wr_ok;
    logic                    ram_we;
    logic                    lin_more;
    logic                    lin_issue;
    logic [CW-1:0]           span;
    logic [CW-1:0]           mid;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [2*KEY_W-1:0]      ram_rdata;
    logic signed [KEY_W-1:0] rd_key;
    logic signed [KEY_W-1:0] rd_batch;
    logic                    key_eq;
    logic                    key_less;

    // entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // count saturated to the table depth
    always_comb begin
        if (32'(r_entry_count) > TABLE_DEPTH) begin
            active_cnt = CW'(TABLE_DEPTH);
        end else begin
            active_cnt = CW'(r_entry_count);
        end
    end

    // write slot range check
    assign wr_ok  = 32'(i_entry_index) < TABLE_DEPTH;
    assign ram_we = i_cmd.wr_en && wr_ok;

    // scan issue and halving midpoint
    assign lin_more  = r_idx < active_cnt;
    assign lin_issue = i_cmd.lin_step && lin_more;
    assign span      = r_hi - r_lo - CW'(1);
    assign mid       = r_lo + (span >> 1);
    assign ram_re    = lin_issue || i_cmd.bin_issue;
    assign ram_raddr = i_cmd.bin_issue ? AW'(mid) : AW'(r_idx);

    // record store: key in the upper half, batch in the lower half
    rtks_ram #(
        .WIDTH (2 * KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ({i_roll_number, i_batch_value}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key   = signed'(ram_rdata[2*KEY_W-1:KEY_W]);
    assign rd_batch = signed'(ram_rdata[KEY_W-1:0]);
    assign key_eq   = rd_key == r_key;
    assign key_less = rd_key < r_key;

    // status to controller
    always_comb begin
        o_status.lin_hit  = r_rd_valid && key_eq;
        o_status.lin_miss = !r_rd_valid && !lin_more;
        o_status.bin_live = r_lo < r_hi;
        o_status.bin_hit  = key_eq;
        o_status.out_free = !r_out_valid || i_ready;
    end

    // search key and bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_key <= i_roll_number;
        end
        if (i_cmd.start_lin) begin
            r_idx <= '0;
        end else if (lin_issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.start_bin) begin
            r_lo <= '0;
            r_hi <= active_cnt;
        end else if (i_cmd.bin_update) begin
            if (key_less) begin
                r_lo <= CW'(r_rd_addr) + CW'(1);
            end else begin
                r_hi <= CW'(r_rd_addr);
            end
        end
        if (ram_re) begin
            r_rd_addr <= ram_raddr;
        end
    end

    // read data tracking for the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_cmd.start_lin) begin
            r_rd_valid <= 1'b0;
        end else if (i_cmd.lin_step) begin
            r_rd_valid <= lin_issue;
        end
    end

    // result holding register
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_wr_res) begin
            r_res_found <= wr_ok;
            r_res_idx   <= wr_ok ? i_entry_index : '0;
            r_res_key   <= wr_ok ? i_roll_number : '0;
            r_res_batch <= wr_ok ? i_batch_value : '0;
        end else if (i_cmd.set_hit) begin
            r_res_found <= 1'b1;
            r_res_idx   <= IDX_W'(r_rd_addr);
            r_res_key   <= rd_key;
            r_res_batch <= rd_batch;
        end else if (i_cmd.set_miss) begin
            r_res_found <= 1'b0;
            r_res_idx   <= '0;
            r_res_key   <= '0;
            r_res_batch <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_out) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
            r_out_key   <= r_res_key;
            r_out_batch <= r_res_batch;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_found               = r_out_found;
    assign o_match_index         = r_out_idx;
    assign o_matched_roll_number = r_out_key;
    assign o_matched_batch       = r_out_batch;

endmodule

/* hdl/rtks_ctrl.sv */
// ----------------------------------------------------------------------------
// rtks_ctrl
// Controller: takes one request item at a time and sequences the write,
// the linear scan or the midpoint halving over the datapath; an unknown request gets a miss.
// ----------------------------------------------------------------------------
module rtks_ctrl import rtks_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_req_ready,
    input  t_status          i_status,
    output t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIN,
        S_BIN_RD,
        S_BIN_CMP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_req_ready = r_state == S_IDLE;
    assign accept      = i_req_valid && o_req_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    case (i_req_type)
                        REQ_WRITE: begin
                            o_cmd.wr_en      = 1'b1;
                            o_cmd.set_wr_res = 1'b1;
                            n_state          = S_FINISH;
                        end
                        REQ_LINEAR: begin
                            o_cmd.start_lin = 1'b1;
                            n_state         = S_LIN;
                        end
                        REQ_BINARY: begin
                            o_cmd.start_bin = 1'b1;
                            n_state         = S_BIN_RD;
                        end
                        default: begin
                            o_cmd.set_miss = 1'b1;
                            n_state        = S_FINISH;
                        end
                    endcase
                end
            end
            S_LIN: begin
                if (i_status.lin_hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_status.lin_miss) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.lin_step = 1'b1;
                end
            end
            S_BIN_RD: begin
                if (i_status.bin_live) begin
                    o_cmd.bin_issue = 1'b1;
                    n_state         = S_BIN_CMP;
                end else begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_BIN_CMP: begin
                if (i_status.bin_hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.bin_update = 1'b1;
                    n_state          = S_BIN_RD;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.push_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/record_table_key_search.sv */
// ----------------------------------------------------------------------------
// record_table_key_search
// Table of roll number / batch records with write, linear search and
// binary (midpoint halving) search requests; one result item per request.
//
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        req_type, entry_index, roll_number,
//                                     batch_value
//   o_rsp     out  valid/ready        found, match_index,
//                                     matched_roll_number, matched_batch
//   i_cfg     in   i_cfg_we           i_cfg_wdata (entry_count)
//
// One request item at a time. A write or unknown request is answered
// directly. Linear search: one record read per cycle from the single RAM
// read port, over slots below entry_count (count saturated to the table
// depth). Binary search: each probe reads the midpoint, then compares it.
// The output register frees the request side once a result is loaded into it.
// Reset is synchronous and active low; the table contents are not cleared.
// ----------------------------------------------------------------------------
module record_table_key_search import rtks_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rtks_req_if.sink         i_req,
    rtks_rsp_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    // sequencing
    rtks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // storage, compare and result registers
    rtks_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_entry_index         (i_req.entry_index),
        .i_roll_number         (i_req.roll_number),
        .i_batch_value         (i_req.batch_value),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_ready               (o_rsp.ready),
        .o_valid               (o_rsp.valid),
        .o_found               (o_rsp.found),
        .o_match_index         (o_rsp.match_index),
        .o_matched_roll_number (o_rsp.matched_roll_number),
        .o_matched_batch       (o_rsp.matched_batch)
    );

`ifndef SYNTHESIS
    // an accepted item always takes the controller out of idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request side still ready after an item was taken");

    // a result without a match carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |->
        (o_rsp.match_index == '0 && o_rsp.matched_roll_number == '0 &&
         o_rsp.matched_batch == '0))
        else $error("not-found result with nonzero fields");

    // a new result appears only as the controller returns to idle
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> i_req.ready)
        else $error("result presented while controller busy");
`endif

endmodule
